[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

[rtl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Types and constants of the chained hash map.
// ----------------------------------------------------------------------------
`default_nettype none
package chm_pkg;
  localparam int NUM_BUCKETS  = 256;
  localparam int POOL_ENTRIES = 1024;
  localparam int TAG_LIMIT    = 16;
  localparam int VALUE_BITS   = 16;
  localparam int TAG_NONE     = 0;

  localparam int BKT_W  = $clog2(NUM_BUCKETS);   // bucket index
  localparam int NODE_W = $clog2(POOL_ENTRIES);  // node address
  localparam int IDX_W  = NODE_W + 1;            // node index incl. "none"
  localparam int BC_W   = BKT_W + 1;
  localparam int KEY_W  = 31;
  localparam int TAG_W  = 8;
  localparam int DATA_W = KEY_W + TAG_W + VALUE_BITS;

  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_ENTRIES);

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_GET       = 3'd1;
  localparam logic [2:0] OP_GET_TAG   = 3'd2;
  localparam logic [2:0] OP_HAS_TAG   = 3'd3;
  localparam logic [2:0] OP_DEL_FIRST = 3'd4;
  localparam logic [2:0] OP_DEL_ALL   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_KEY   = 3'd2;
  localparam logic [2:0] ST_BAD_TAG   = 3'd3;
  localparam logic [2:0] ST_NULL_VAL  = 3'd4;
  localparam logic [2:0] ST_DUP_TAG   = 3'd5;
  localparam logic [2:0] ST_POOL_FULL = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_HEAD_RD, S_HEAD_WAIT, S_WALK, S_RD, S_CMP,
    S_UNL_A, S_UNL_B, S_ALLOC, S_ALLOC_WAIT, S_STORE, S_DONE
  } state_t;
endpackage
`default_nettype wire

[rtl/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/chained_hash_map_with_tag.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_with_tag
// Separate-chaining hash map over a fixed node pool, one sequencer walking
// the chains through RAM reads.
// ----------------------------------------------------------------------------
// channel   | direction | signals
// request   | in        | start, operation, key, tag, value_handle (busy out)
// result    | out       | done, status, found, found_value
// config    | in        | bucket_count_we, bucket_count_wdata
//
// busy stays high from acceptance to the end of done. An early reject goes
// straight to done; else bit-serial remainder, head read, walk/read/compare
// per chain node, a walk at chain end, unlink A/B per deletion, allocate/wait/
// store for an insert (allocate only if the pool is full), then done. Reset
// is synchronous; no clearing pass is needed (bucket valid bits and a pool
// fill count). done is a one-cycle strobe; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module chained_hash_map_with_tag (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic signed [31:0] key,
  input  wire logic [7:0]  tag,
  input  wire logic [15:0] value_handle,
  output logic             done,
  output logic [2:0]       status,
  output logic             found,
  output logic [15:0]      found_value,
  input  wire logic        bucket_count_we,
  input  wire logic [8:0]  bucket_count_wdata
);
  chm_pkg::state_t state, state_next;

  logic [chm_pkg::BC_W-1:0]       bucket_count;
  logic [chm_pkg::BC_W-1:0]       bc_eff;
  logic [2:0]                     op;
  logic [chm_pkg::KEY_W-1:0]      key_r;
  logic [chm_pkg::TAG_W-1:0]      tag_r;
  logic [chm_pkg::VALUE_BITS-1:0] val_r;
  logic [4:0]                     cnt;
  logic [chm_pkg::BKT_W-1:0]      rem, rem_next;
  logic [chm_pkg::BC_W-1:0]       rem_t;
  logic [chm_pkg::IDX_W-1:0]      n, prev, head_idx, next_idx, free_head, fill;
  logic [chm_pkg::NUM_BUCKETS-1:0] head_valid;

  logic                           head_we, link_we, data_we;
  logic [chm_pkg::BKT_W-1:0]      head_waddr, head_raddr;
  logic [chm_pkg::IDX_W-1:0]      head_wdata, head_q, link_wdata, link_q;
  logic [chm_pkg::NODE_W-1:0]     link_waddr, link_raddr, data_waddr, data_raddr;
  logic [chm_pkg::DATA_W-1:0]     data_wdata, data_q;

  logic                           pre_reject, tag_bad, use_tag, match;
  logic [2:0]                     pre_status;
  logic [chm_pkg::IDX_W-1:0]      head_eff;

  always_comb begin
    if (bucket_count == '0) begin
      bc_eff = chm_pkg::BC_W'(1);
    end else if (bucket_count > chm_pkg::BC_W'(chm_pkg::NUM_BUCKETS)) begin
      bc_eff = chm_pkg::BC_W'(chm_pkg::NUM_BUCKETS);
    end else begin
      bc_eff = bucket_count;
    end
  end

  // restoring remainder step, one key bit per cycle
  assign rem_t    = {rem, key_r[cnt]};
  assign rem_next = (rem_t >= bc_eff) ? chm_pkg::BKT_W'(rem_t - bc_eff)
                                      : chm_pkg::BKT_W'(rem_t);

  assign tag_bad = {1'b0, tag} >= 9'(chm_pkg::TAG_LIMIT);

  always_comb begin
    pre_reject = 1'b1;
    pre_status = chm_pkg::ST_NOT_FOUND;
    if (operation > chm_pkg::OP_DEL_ALL) begin
      pre_status = chm_pkg::ST_NOT_FOUND;
    end else if (key[31]) begin
      pre_status = chm_pkg::ST_BAD_KEY;
    end else if ((operation == chm_pkg::OP_INSERT || operation == chm_pkg::OP_GET_TAG ||
                  operation == chm_pkg::OP_HAS_TAG) && tag_bad) begin
      pre_status = chm_pkg::ST_BAD_TAG;
    end else if (operation == chm_pkg::OP_INSERT && value_handle == '0) begin
      pre_status = chm_pkg::ST_NULL_VAL;
    end else begin
      pre_reject = 1'b0;
    end
  end

  assign use_tag  = (op == chm_pkg::OP_INSERT || op == chm_pkg::OP_GET_TAG ||
                     op == chm_pkg::OP_HAS_TAG);
  assign match    = (data_q[chm_pkg::DATA_W-1 -: chm_pkg::KEY_W] == key_r) &&
                    (!use_tag || data_q[chm_pkg::VALUE_BITS +: chm_pkg::TAG_W] == tag_r);
  assign head_eff = head_valid[rem] ? head_q : chm_pkg::NIL;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      chm_pkg::S_IDLE: begin
        if (start) begin
          state_next = pre_reject ? chm_pkg::S_DONE : chm_pkg::S_DIV;
        end
      end
      chm_pkg::S_DIV: begin
        if (cnt == '0) begin
          state_next = chm_pkg::S_HEAD_RD;
        end
      end
      chm_pkg::S_HEAD_RD:   state_next = chm_pkg::S_HEAD_WAIT;
      chm_pkg::S_HEAD_WAIT: begin
        state_next = (op == chm_pkg::OP_INSERT && tag_r == chm_pkg::TAG_W'(chm_pkg::TAG_NONE))
                     ? chm_pkg::S_ALLOC : chm_pkg::S_WALK;
      end
      chm_pkg::S_WALK: begin
        if (n != chm_pkg::NIL) begin
          state_next = chm_pkg::S_RD;
        end else if (op == chm_pkg::OP_INSERT) begin
          state_next = chm_pkg::S_ALLOC;
        end else begin
          state_next = chm_pkg::S_DONE;
        end
      end
      chm_pkg::S_RD:  state_next = chm_pkg::S_CMP;
      chm_pkg::S_CMP: begin
        if (!match) begin
          state_next = chm_pkg::S_WALK;
        end else if (op == chm_pkg::OP_DEL_FIRST || op == chm_pkg::OP_DEL_ALL) begin
          state_next = chm_pkg::S_UNL_A;
        end else begin
          state_next = chm_pkg::S_DONE;
        end
      end
      chm_pkg::S_UNL_A: state_next = chm_pkg::S_UNL_B;
      chm_pkg::S_UNL_B: begin
        state_next = (op == chm_pkg::OP_DEL_ALL) ? chm_pkg::S_WALK : chm_pkg::S_DONE;
      end
      chm_pkg::S_ALLOC: begin
        state_next = (free_head == chm_pkg::NIL) ? chm_pkg::S_DONE : chm_pkg::S_ALLOC_WAIT;
      end
      chm_pkg::S_ALLOC_WAIT: state_next = chm_pkg::S_STORE;
      chm_pkg::S_STORE:      state_next = chm_pkg::S_DONE;
      chm_pkg::S_DONE:       state_next = chm_pkg::S_IDLE;
      default:               state_next = chm_pkg::S_IDLE;
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    busy       = (state != chm_pkg::S_IDLE);
    done       = (state == chm_pkg::S_DONE);
    head_we    = 1'b0;
    head_waddr = rem;
    head_wdata = next_idx;
    head_raddr = rem;
    link_we    = 1'b0;
    link_waddr = prev[chm_pkg::NODE_W-1:0];
    link_wdata = next_idx;
    link_raddr = n[chm_pkg::NODE_W-1:0];
    data_we    = 1'b0;
    data_waddr = free_head[chm_pkg::NODE_W-1:0];
    data_wdata = {key_r, tag_r, val_r};
    data_raddr = n[chm_pkg::NODE_W-1:0];
    case (state)
      chm_pkg::S_UNL_A: begin
        if (prev == chm_pkg::NIL) begin
          head_we = 1'b1;
        end else begin
          link_we = 1'b1;
        end
      end
      chm_pkg::S_UNL_B: begin
        link_we    = 1'b1;
        link_waddr = n[chm_pkg::NODE_W-1:0];
        link_wdata = free_head;
      end
      chm_pkg::S_ALLOC: begin
        link_raddr = free_head[chm_pkg::NODE_W-1:0];
      end
      chm_pkg::S_STORE: begin
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = free_head[chm_pkg::NODE_W-1:0];
        link_wdata = head_idx;
        head_we    = 1'b1;
        head_wdata = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chm_pkg::S_IDLE;
      bucket_count <= chm_pkg::BC_W'(256);
      head_valid   <= '0;
      free_head    <= '0;
      fill         <= '0;
    end else begin
      state <= state_next;
      if (bucket_count_we) begin
        bucket_count <= bucket_count_wdata;
      end
      if (head_we) begin
        head_valid[head_waddr] <= 1'b1;
      end
      case (state)
        chm_pkg::S_UNL_B: free_head <= n;
        chm_pkg::S_ALLOC_WAIT: begin
          // nodes from the fill mark upward are still in reset order
          if (free_head == fill) begin
            fill <= fill + 1'b1;
          end
        end
        chm_pkg::S_STORE: free_head <= next_idx;
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      chm_pkg::S_IDLE: begin
        op          <= operation;
        key_r       <= key[30:0];
        tag_r       <= tag;
        val_r       <= value_handle;
        status      <= pre_status;
        found       <= 1'b0;
        found_value <= '0;
        rem         <= '0;
        cnt         <= 5'd30;
        prev        <= chm_pkg::NIL;
      end
      chm_pkg::S_DIV: begin
        rem <= rem_next;
        cnt <= cnt - 1'b1;
      end
      chm_pkg::S_HEAD_WAIT: begin
        head_idx <= head_eff;
        n        <= head_eff;
      end
      chm_pkg::S_CMP: begin
        if (match) begin
          case (op)
            chm_pkg::OP_INSERT: begin
              status      <= chm_pkg::ST_DUP_TAG;
              found       <= 1'b1;
              found_value <= data_q[chm_pkg::VALUE_BITS-1:0];
            end
            chm_pkg::OP_DEL_FIRST, chm_pkg::OP_DEL_ALL: begin
              if (!found) begin
                found_value <= data_q[chm_pkg::VALUE_BITS-1:0];
              end
              status   <= chm_pkg::ST_OK;
              found    <= 1'b1;
              next_idx <= link_q;
            end
            default: begin
              status      <= chm_pkg::ST_OK;
              found       <= 1'b1;
              found_value <= data_q[chm_pkg::VALUE_BITS-1:0];
            end
          endcase
        end else begin
          prev <= n;
          n    <= link_q;
        end
      end
      chm_pkg::S_UNL_B: n <= next_idx;
      chm_pkg::S_ALLOC: begin
        if (free_head == chm_pkg::NIL) begin
          status <= chm_pkg::ST_POOL_FULL;
        end
      end
      chm_pkg::S_ALLOC_WAIT: begin
        next_idx <= (free_head == fill) ? fill + 1'b1 : link_q;
      end
      chm_pkg::S_STORE: status <= chm_pkg::ST_OK;
      default: begin
      end
    endcase
  end

  chm_ram #(.WIDTH(chm_pkg::IDX_W), .DEPTH(chm_pkg::NUM_BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_q)
  );

  chm_ram #(.WIDTH(chm_pkg::IDX_W), .DEPTH(chm_pkg::POOL_ENTRIES)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_q)
  );

  chm_ram #(.WIDTH(chm_pkg::DATA_W), .DEPTH(chm_pkg::POOL_ENTRIES)) u_nodes (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(data_raddr), .rdata(data_q)
  );

  `ASSERT_CLK(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `ASSERT_CLK(a_done_idle, clk, rst, done |=> !busy)
  `ASSERT_CLK(a_found_status, clk, rst,
    (done && found) |-> (status == chm_pkg::ST_OK || status == chm_pkg::ST_DUP_TAG))
  `ASSERT_NEVER(a_fill_range, clk, rst, fill > chm_pkg::NIL || free_head > chm_pkg::NIL)
endmodule
`default_nettype wire
